/* rtl/core/sxl_pkg.sv */
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types, character codes and helper functions for the S-expression
// lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sxl_pkg;

  // Default saturation point of the token text length.
  localparam int MAX_TEXT_DEF = 2047;

  // Fixed field widths of the result item and the number accumulator.
  localparam int TEXT_LEN_W = 11;
  localparam int ACCUM_W    = 31;
  localparam int INT_W      = 32;

  // Largest magnitude the number accumulator holds.
  localparam logic [ACCUM_W-1:0] ACCUM_MAX = 31'h7FFF_FFFF;

  // Result queue geometry.
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int LVL_W     = $clog2(RES_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Input action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result type codes.
  localparam logic RES_ECHO = 1'b0;
  localparam logic RES_DONE = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_SYM  = 3'd1,
    MODE_KW   = 3'd2,
    MODE_STR  = 3'd3,
    MODE_NUM  = 3'd4
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_STR   = 3'd2,
    KIND_SYM   = 3'd3,
    KIND_KW    = 3'd4,
    KIND_INT   = 3'd5
  } token_kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic                   result_type;
    logic [7:0]             text_byte;
    token_kind_t            token_kind;
    logic [TEXT_LEN_W-1:0]  text_length;
    logic                   quoted;
    logic signed [INT_W-1:0] num_value;
    logic                   overflow;
    logic                   last;
  } out_item_t;

  // Token state apart from the text count, whose width follows MAX_TEXT.
  typedef struct packed {
    lex_mode_t          mode;
    logic               minus_seen;
    logic               quote_seen;
    logic               overflow_seen;
    logic [ACCUM_W-1:0] number_accum;
  } lex_state_t;

  // Status of the result queue seen by the top level.
  typedef struct packed {
    logic             room;
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

  localparam lex_state_t LEX_CLEAR = '{
    mode:          MODE_IDLE,
    minus_seen:    1'b0,
    quote_seen:    1'b0,
    overflow_seen: 1'b0,
    number_accum:  '0
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c inside {CH_MINUS, CH_UNDER});
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sxl_step.sv */
// ----------------------------------------------------------------------------
// sxl_step
// Per-byte lexer decision: from the current token state and one input item it
// forms the next state and up to two result items.
// ----------------------------------------------------------------------------
`default_nettype none

module sxl_step import sxl_pkg::*; #(
  parameter int   MAX_TEXT = MAX_TEXT_DEF,
  localparam int  TEXT_W   = $clog2(MAX_TEXT + 1)
) (
  input  in_item_t          item,
  input  lex_state_t        cur,
  input  logic [TEXT_W-1:0] cur_count,
  output lex_state_t        nxt,
  output logic [TEXT_W-1:0] nxt_count,
  output out_item_t         res0,
  output out_item_t         res1,
  output logic [1:0]        res_n
);

  localparam int EXT_W = (TEXT_W > TEXT_LEN_W) ? TEXT_W : TEXT_LEN_W;

  logic [7:0]            c;
  logic                  text_full;
  logic [EXT_W-1:0]      count_ext;
  logic [TEXT_LEN_W-1:0] cur_len;
  logic [ACCUM_W+3:0]    digit_sum;
  logic                  digit_sat;
  logic [INT_W-1:0]      mag;
  out_item_t             echo;
  out_item_t             fin;
  logic                  fin_valid;
  out_item_t             idle_res;
  logic                  idle_valid;
  lex_state_t            idle_state;
  logic [TEXT_W-1:0]     idle_count;

  assign c         = item.ch;
  assign text_full = cur_count >= TEXT_W'(MAX_TEXT);
  assign count_ext = EXT_W'(cur_count);
  assign cur_len   = count_ext[TEXT_LEN_W-1:0];
  assign mag       = {1'b0, cur.number_accum};

  // Decimal accumulate: accum * 10 + digit, built from two shifts.
  assign digit_sum = ({4'b0, cur.number_accum} << 3) + ({4'b0, cur.number_accum} << 1)
                     + (ACCUM_W + 4)'(c[3:0]);
  assign digit_sat = digit_sum > (ACCUM_W + 4)'(ACCUM_MAX);

  // Echo item for the current byte.
  always_comb begin
    echo             = '0;
    echo.result_type = RES_ECHO;
    echo.text_byte   = c;
  end

  // Completion of a pending symbol, keyword or integer.
  always_comb begin
    fin             = '0;
    fin.result_type = RES_DONE;
    fin.overflow    = cur.overflow_seen;
    fin_valid       = 1'b1;
    case (cur.mode)
      MODE_SYM: begin
        fin.token_kind  = KIND_SYM;
        fin.text_length = cur_len;
        fin.quoted      = cur.quote_seen;
      end
      MODE_KW: begin
        fin.token_kind  = KIND_KW;
        fin.text_length = cur_len;
      end
      MODE_NUM: begin
        fin.token_kind = KIND_INT;
        fin.num_value  = cur.minus_seen ? (INT_W'(0) - mag) : mag;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  // Handling of a byte from the cleared idle state.
  always_comb begin
    idle_state           = LEX_CLEAR;
    idle_count           = '0;
    idle_res             = '0;
    idle_res.result_type = RES_DONE;
    idle_valid           = 1'b0;
    if (c == CH_LPAREN) begin
      idle_res.token_kind = KIND_OPEN;
      idle_valid          = 1'b1;
    end else if (c == CH_RPAREN) begin
      idle_res.token_kind = KIND_CLOSE;
      idle_valid          = 1'b1;
    end else if (c == CH_DQUOTE) begin
      idle_state.mode = MODE_STR;
    end else if (c == CH_COLON) begin
      idle_state.mode = MODE_KW;
    end else if (c == CH_QUOTE) begin
      idle_state.mode       = MODE_SYM;
      idle_state.quote_seen = 1'b1;
    end else if (is_alpha(c)) begin
      idle_state.mode = MODE_SYM;
      idle_count      = TEXT_W'(1);
      idle_res        = echo;
      idle_valid      = 1'b1;
    end else if (c == CH_MINUS) begin
      idle_state.mode       = MODE_NUM;
      idle_state.minus_seen = 1'b1;
    end else if (is_digit(c)) begin
      idle_state.mode         = MODE_NUM;
      idle_state.number_accum = ACCUM_W'(c[3:0]);
      idle_res                = echo;
      idle_valid              = 1'b1;
    end
  end

  // Main decision by mode, then the last mark on the final item.
  always_comb begin
    nxt       = cur;
    nxt_count = cur_count;
    res0      = '0;
    res1      = '0;
    res_n     = 2'd0;
    if (item.action == ACT_END) begin
      nxt       = LEX_CLEAR;
      nxt_count = '0;
      res0      = fin;
      res_n     = fin_valid ? 2'd1 : 2'd0;
    end else begin
      case (cur.mode)
        MODE_STR: begin
          if (c == CH_DQUOTE) begin
            res0             = '0;
            res0.result_type = RES_DONE;
            res0.token_kind  = KIND_STR;
            res0.text_length = cur_len;
            res0.overflow    = cur.overflow_seen;
            res_n            = 2'd1;
            nxt              = LEX_CLEAR;
            nxt_count        = '0;
          end else if (text_full) begin
            nxt.overflow_seen = 1'b1;
          end else begin
            nxt_count = cur_count + TEXT_W'(1);
            res0      = echo;
            res_n     = 2'd1;
          end
        end
        MODE_SYM, MODE_KW: begin
          if (is_word(c)) begin
            if (text_full) begin
              nxt.overflow_seen = 1'b1;
            end else begin
              nxt_count = cur_count + TEXT_W'(1);
              res0      = echo;
              res_n     = 2'd1;
            end
          end else begin
            nxt       = idle_state;
            nxt_count = idle_count;
            res0      = fin;
            res1      = idle_res;
            res_n     = idle_valid ? 2'd2 : 2'd1;
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            nxt.number_accum = digit_sat ? ACCUM_MAX : digit_sum[ACCUM_W-1:0];
            if (digit_sat) begin
              nxt.overflow_seen = 1'b1;
            end
            res0  = echo;
            res_n = 2'd1;
          end else begin
            nxt       = idle_state;
            nxt_count = idle_count;
            res0      = fin;
            res1      = idle_res;
            res_n     = idle_valid ? 2'd2 : 2'd1;
          end
        end
        default: begin
          nxt       = idle_state;
          nxt_count = idle_count;
          res0      = idle_res;
          res_n     = idle_valid ? 2'd1 : 2'd0;
        end
      endcase
    end
    res0.last = (res_n == 2'd1);
    res1.last = (res_n == 2'd2);
  end

endmodule

`default_nettype wire

/* rtl/core/sxl_res_fifo.sv */
// ----------------------------------------------------------------------------
// sxl_res_fifo
// Small result queue: takes up to two result items per cycle and hands them
// out one per cycle in order while pop is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sxl_res_fifo import sxl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  out_item_t  push0,
  input  out_item_t  push1,
  input  logic       pop,
  output out_item_t  head,
  output logic       head_valid,
  output fifo_stat_t stat
);

  out_item_t        mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign head       = mem[rd_ptr];
  assign head_valid = level != '0;
  assign stat.level = level;
  // Room for the largest burst one item can cause.
  assign stat.room  = level <= LVL_W'(RES_DEPTH - 2);

  // Storage writes at the tail.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level + LVL_W'(push_n) - LVL_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sexpr_lexer.sv */
// ----------------------------------------------------------------------------
// sexpr_lexer
// Byte-serial S-expression tokenizer. Each input item is one source byte or
// an end-of-input mark; results are echoed text bytes and token completions.
//
// Usage: in_valid/in_ready carry in_data (action, ch); out_valid/out_ready
// carry out_data, one result item per transfer, with last set on the final
// result that an input item causes. An item may cause zero, one or two
// results.
// Path: an accepted item waits in the input register until the queue has
// room; then its results are written to the result queue and offered in order.
// Throughput: one item per cycle while each item gives at most one result
// and the receiver keeps up; an item giving two results needs a second
// transfer on the single-result output port.
// The per-byte decision is one pass of combinational logic between the input
// register and a four-entry result queue, which must have two free slots
// before an item is processed.
// Reset: the token state returns to idle and the queue is emptied.
// Stall: when the receiver holds out_ready low the queue fills, then the
// input register holds its item and in_ready drops until space returns.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_lexer import sxl_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int TEXT_W = $clog2(MAX_TEXT + 1);

  in_item_t          in_q;
  logic              in_full;
  lex_state_t        st;
  logic [TEXT_W-1:0] text_count;
  lex_state_t        st_next;
  logic [TEXT_W-1:0] text_count_next;
  out_item_t         res0;
  out_item_t         res1;
  logic [1:0]        res_n;
  logic              proc;
  fifo_stat_t        fstat;

  // Process the held item once the queue can absorb two results.
  assign proc     = in_full && fstat.room;
  assign in_ready = !in_full || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Token state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= LEX_CLEAR;
      text_count <= '0;
    end else if (proc) begin
      st         <= st_next;
      text_count <= text_count_next;
    end
  end

  sxl_step #(
    .MAX_TEXT (MAX_TEXT)
  ) u_step (
    .item      (in_q),
    .cur       (st),
    .cur_count (text_count),
    .nxt       (st_next),
    .nxt_count (text_count_next),
    .res0      (res0),
    .res1      (res1),
    .res_n     (res_n)
  );

  sxl_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (proc ? res_n : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_valid && out_ready),
    .head       (out_data),
    .head_valid (out_valid),
    .stat       (fstat)
  );

`ifndef SYNTH
  // The queue never holds more items than it has entries.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.level <= LVL_W'(RES_DEPTH))
    else $error("result queue level exceeds its depth");

  // When one item gives two results, the first one is a completion.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (proc && res_n == 2'd2) |-> (res0.result_type == RES_DONE && res1.last))
    else $error("two results without a leading completion");

  // A held item that is not processed stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !proc) |=> (in_full && $stable(in_q)))
    else $error("input register lost an unprocessed item");

  // The text count saturates at its limit.
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    text_count <= TEXT_W'(MAX_TEXT))
    else $error("text count above its limit");
`endif

endmodule

`default_nettype wire

/* tb/tb_sexpr_lexer.sv */
// ----------------------------------------------------------------------------
// tb_sexpr_lexer
// Self-checking bench for the byte-serial S-expression tokenizer. A directed
// run of tokens and edge cases is followed by random token streams, noise
// and integers at the magnitude limit. Every accepted item is run through a
// behavioral tokenizer that queues the echo and completion results it must
// cause. Each delivered result is checked field by field against the oldest
// queued one. Both handshakes stall at random, with one long stretch at
// full rate.
// ----------------------------------------------------------------------------
module tb_sexpr_lexer import sxl_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_CAP  = MAX_TEXT_DEF;
  localparam int CYC_LIMIT = 400000;
  localparam int MAX_SHOWN = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  sexpr_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Items waiting to be driven and results the tokenizer must still deliver.
  in_item_t  item_q[$];
  out_item_t want_q[$];

  // Token state of the behavioral tokenizer.
  lex_mode_t          st_mode;
  logic               st_minus;
  logic               st_quote;
  logic               st_ovf;
  int unsigned        st_count;
  logic [ACCUM_W-1:0] st_accum;

  int   n_err;
  int   n_items;
  int   n_acc;
  int   n_cyc;
  int   in_gap;
  int   out_gap;
  logic in_taken;
  logic quiet;

  string bound_nums[4] = '{"2147483647", "2147483648", "99999999999", "0"};

  // No idling at all while this window of accepted items passes.
  assign quiet = (n_acc >= 300) && (n_acc < 900);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral tokenizer
  // ---------------------------------------------------------------------------

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_ch(input logic [7:0] c);
    return letter_ch(c) || digit_ch(c) || c == CH_MINUS || c == CH_UNDER;
  endfunction

  task automatic tok_clear();
    st_mode  = MODE_IDLE;
    st_minus = 1'b0;
    st_quote = 1'b0;
    st_ovf   = 1'b0;
    st_count = 0;
    st_accum = '0;
  endtask

  task automatic emit(input logic rt, input logic [7:0] b, input token_kind_t k,
                      input int unsigned len, input logic q, input logic [31:0] v,
                      input logic o);
    out_item_t r;
    r.result_type = rt;
    r.text_byte   = b;
    r.token_kind  = k;
    r.text_length = TEXT_LEN_W'(len);
    r.quoted      = q;
    r.num_value   = v;
    r.overflow    = o;
    r.last        = 1'b0;
    want_q.push_back(r);
  endtask

  // Echo results carry zeros in every completion field; kind zero is KIND_OPEN.
  task automatic append_text(input logic [7:0] c);
    if (st_count >= TEXT_CAP) begin
      st_ovf = 1'b1;
    end else begin
      st_count++;
      emit(RES_ECHO, c, KIND_OPEN, 0, 1'b0, '0, 1'b0);
    end
  endtask

  // Digits are always echoed; the magnitude sticks at its maximum.
  task automatic append_digit(input logic [7:0] c);
    longint unsigned v;
    v = longint'(st_accum) * 10 + (c - "0");
    if (v > ACCUM_MAX) begin
      v = ACCUM_MAX;
      st_ovf = 1'b1;
    end
    st_accum = v[ACCUM_W-1:0];
    emit(RES_ECHO, c, KIND_OPEN, 0, 1'b0, '0, 1'b0);
  endtask

  // Completes a pending symbol, keyword or integer and returns to idle.
  task automatic close_token();
    case (st_mode)
      MODE_SYM: emit(RES_DONE, 8'h00, KIND_SYM, st_count, st_quote, '0, st_ovf);
      MODE_KW:  emit(RES_DONE, 8'h00, KIND_KW, st_count, 1'b0, '0, st_ovf);
      MODE_NUM: begin
        emit(RES_DONE, 8'h00, KIND_INT, 0, 1'b0,
             st_minus ? -{1'b0, st_accum} : {1'b0, st_accum}, st_ovf);
      end
      default: ;
    endcase
    tok_clear();
  endtask

  // Handles a byte seen in the idle mode.
  task automatic start_token(input logic [7:0] c);
    tok_clear();
    if (c == CH_LPAREN) begin
      emit(RES_DONE, 8'h00, KIND_OPEN, 0, 1'b0, '0, 1'b0);
    end else if (c == CH_RPAREN) begin
      emit(RES_DONE, 8'h00, KIND_CLOSE, 0, 1'b0, '0, 1'b0);
    end else if (c == CH_DQUOTE) begin
      st_mode = MODE_STR;
    end else if (c == CH_COLON) begin
      st_mode = MODE_KW;
    end else if (c == CH_QUOTE) begin
      st_mode  = MODE_SYM;
      st_quote = 1'b1;
    end else if (letter_ch(c)) begin
      st_mode = MODE_SYM;
      append_text(c);
    end else if (c == CH_MINUS) begin
      st_mode  = MODE_NUM;
      st_minus = 1'b1;
    end else if (digit_ch(c)) begin
      st_mode = MODE_NUM;
      append_digit(c);
    end
  endtask

  // Queues every result that one accepted item causes, marking the final one.
  task automatic lex_step(input in_item_t it);
    logic [7:0] c;
    int         n0;
    c  = it.ch;
    n0 = want_q.size();
    if (it.action == ACT_END) begin
      // A pending string is dropped here without a result.
      close_token();
    end else begin
      case (st_mode)
        MODE_STR: begin
          if (c == CH_DQUOTE) begin
            emit(RES_DONE, 8'h00, KIND_STR, st_count, 1'b0, '0, st_ovf);
            tok_clear();
          end else begin
            append_text(c);
          end
        end
        MODE_SYM, MODE_KW: begin
          if (word_ch(c)) begin
            append_text(c);
          end else begin
            close_token();
            start_token(c);
          end
        end
        MODE_NUM: begin
          if (digit_ch(c)) begin
            append_digit(c);
          end else begin
            close_token();
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
    end
    if (want_q.size() > n0) begin
      want_q[want_q.size()-1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic field_chk(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      if (n_err < MAX_SHOWN) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
      n_err++;
    end
  endtask

  // Sample both handshakes at the rising edge; predict, then check.
  always @(posedge clk) begin
    out_item_t w;
    n_cyc <= n_cyc + 1;
    if (n_cyc >= CYC_LIMIT) begin
      $display("tb_sexpr_lexer: FAIL");
      $finish;
    end else if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        lex_step(in_data);
        n_acc <= n_acc + 1;
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          if (n_err < MAX_SHOWN) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
          end
          n_err++;
        end else begin
          w = want_q.pop_front();
          field_chk("result_type", 32'(w.result_type), 32'(out_data.result_type));
          field_chk("text_byte", 32'(w.text_byte), 32'(out_data.text_byte));
          field_chk("token_kind", 32'(w.token_kind), 32'(out_data.token_kind));
          field_chk("text_length", 32'(w.text_length), 32'(out_data.text_length));
          field_chk("quoted", 32'(w.quoted), 32'(out_data.quoted));
          field_chk("num_value", w.num_value, out_data.num_value);
          field_chk("overflow", 32'(w.overflow), 32'(out_data.overflow));
          field_chk("last", 32'(w.last), 32'(out_data.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both changing at the falling edge
  // ---------------------------------------------------------------------------

  // Idle gaps start at random and come in bursts of random length.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (!quiet && in_gap == 0 && $urandom_range(0, 99) < 2) begin
        in_gap = $urandom_range(1, 7);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= item_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!quiet && out_gap == 0 && $urandom_range(0, 99) < 2) begin
      out_gap = $urandom_range(1, 7);
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic put_item(input logic act, input logic [7:0] c);
    in_item_t it;
    it.action = act;
    it.ch     = c;
    item_q.push_back(it);
    n_items++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_item(ACT_BYTE, s[i]);
    end
  endtask

  task automatic put_end();
    put_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] rand_word();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    if (r < 62) return 8'("0" + (r - 52));
    return (r == 62) ? CH_MINUS : CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  // Any byte but the closing double quote.
  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CH_DQUOTE) ? 8'h20 : c;
  endfunction

  initial begin
    int  pick;
    int  len;
    bit  neg;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    in_taken  = 1'b0;
    n_err     = 0;
    n_items   = 0;
    n_acc     = 0;
    n_cyc     = 0;
    in_gap    = 0;
    out_gap   = 0;
    tok_clear();

    // Directed: parens, a string holding a paren, a quoted symbol and a quote
    // pair, a short keyword ended by a paren, a lone minus, an ignored byte,
    // end of input while idle, an unterminated string, an integer ended by a
    // paren and one ended by a letter.
    put_text("()\"a(\"'x'':k_)-");
    put_end();
    put_item(ACT_BYTE, 8'hFF);
    put_end();
    put_text("\"");
    put_end();
    put_text("-5(9z ");

    // Random token streams with noise and early ends of input.
    while (n_items < 1600) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        put_item(ACT_BYTE, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      end else if (pick < 30) begin
        put_item(ACT_BYTE, CH_DQUOTE);
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) put_item(ACT_BYTE, rand_text());
        if ($urandom_range(0, 9) == 0) put_end();
        else put_item(ACT_BYTE, CH_DQUOTE);
      end else if (pick < 50) begin
        if ($urandom_range(0, 9) < 3) put_item(ACT_BYTE, CH_QUOTE);
        else put_item(ACT_BYTE, rand_letter());
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) put_item(ACT_BYTE, rand_word());
      end else if (pick < 62) begin
        put_item(ACT_BYTE, CH_COLON);
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) put_item(ACT_BYTE, rand_word());
      end else if (pick < 84) begin
        neg = ($urandom_range(0, 2) == 0);
        if (neg) put_item(ACT_BYTE, CH_MINUS);
        if ($urandom_range(0, 9) == 0) begin
          put_text(bound_nums[$urandom_range(0, 3)]);
        end else begin
          len = $urandom_range(neg ? 0 : 1, 12);
          for (int i = 0; i < len; i++) begin
            put_item(ACT_BYTE, 8'("0" + $urandom_range(0, 9)));
          end
        end
      end else if (pick < 94) begin
        put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        put_end();
      end

      // Separator: blank, paren, nothing at all, or any byte.
      pick = $urandom_range(0, 9);
      if (pick < 4) put_item(ACT_BYTE, 8'h20);
      else if (pick < 6) put_item(ACT_BYTE, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      else if (pick >= 8) put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end
    put_end();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain, then give a late or spurious result time to show up.
    while (item_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (n_err == 0) begin
      $display("tb_sexpr_lexer: PASS");
    end else begin
      $display("tb_sexpr_lexer: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sxl_pkg.sv
rtl/core/sxl_step.sv
rtl/core/sxl_res_fifo.sv
rtl/core/sexpr_lexer.sv
tb/tb_sexpr_lexer.sv
